// ===== design/assert_macros.svh =====
// Assertion macros used by the frame decoder sequencer module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define AFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every rising clock edge, reset included.
`define AFD_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ===== design/afd_pkg.sv =====
// Types and constants shared by the ADPCM frame decoder modules.
package afd_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 16;
	localparam int NIB_W         = 4;
	localparam int SCALE_W       = 4;
	localparam int PRED_W        = 4;
	localparam int HEADER_W      = 8;
	localparam int PAYLOAD_W     = 56;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 3;
	localparam int BANK_COUNT    = 4;
	localparam int FRAME_SAMPLES = 14;
	localparam int PRED_SHIFT    = 11;
	localparam int PROD_W        = 2 * COEF_W;
	localparam int ACC_W         = PROD_W + 1;
	localparam int CNT_W         = 4;

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_SAMPLES - 1);

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_EMIT
	} state_t;

	// Datapath controls issued by the sequencer each cycle.
	typedef struct packed {
		logic start;
		logic mul_en;
		logic mul_sel;
		logic emit;
	} ctrl_t;

endpackage

// ===== design/afd_coef_regs.sv =====
// Coefficient bank registers and predictor coefficient selection.
module afd_coef_regs
	import afd_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [CFG_INDEX_W-1:0]        wr_index,
	input  logic [CFG_DATA_W-1:0]         wr_data,
	input  logic [PRED_W-1:0]             pred,
	output logic signed [COEF_W-1:0]      a0,
	output logic signed [COEF_W-1:0]      a1
);

	logic [CFG_DATA_W-1:0] bank_q [BANK_COUNT];
	logic [PRED_W-2:0]     pred_eff;
	logic [1:0]            bank_sel;
	logic [PROD_W-1:0]     half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_COUNT; i++) bank_q[i] <= '0;
		end else if (wr_en && (wr_index < CFG_INDEX_W'(BANK_COUNT))) begin
			bank_q[wr_index[1:0]] <= wr_data;
		end
	end

	// Predictor indexes eight and above fall back to predictor zero.
	assign pred_eff = pred[PRED_W-1] ? '0 : pred[PRED_W-2:0];
	assign bank_sel = pred_eff[2:1];

	always_comb begin
		half = pred_eff[0] ? bank_q[bank_sel][CFG_DATA_W-1:PROD_W]
		                   : bank_q[bank_sel][PROD_W-1:0];
		a0   = $signed(half[COEF_W-1:0]);
		a1   = $signed(half[PROD_W-1:COEF_W]);
	end

endmodule

// ===== design/afd_datapath.sv =====
// Shared multiplier, accumulator, saturation and sample history.
module afd_datapath
	import afd_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctrl_t                         ctrl,
	input  logic [SCALE_W-1:0]            scale,
	input  logic [PAYLOAD_W-1:0]          payload,
	input  logic                          load_history,
	input  logic signed [SAMPLE_W-1:0]    history_newer,
	input  logic signed [SAMPLE_W-1:0]    history_older,
	input  logic signed [COEF_W-1:0]      coef_a0,
	input  logic signed [COEF_W-1:0]      coef_a1,
	output logic signed [SAMPLE_W-1:0]    sample
);

	localparam int PRED_VAL_W = ACC_W - PRED_SHIFT;
	localparam int SHIFTED_W  = 20;
	localparam int TOTAL_W    = PRED_VAL_W + 1;

	logic signed [COEF_W-1:0]    a0_q, a1_q;
	logic [SCALE_W-1:0]          scale_q;
	logic [PAYLOAD_W-1:0]        payload_q;
	logic signed [SAMPLE_W-1:0]  hn_q, ho_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [SAMPLE_W-1:0]  sample_q;

	logic signed [COEF_W-1:0]    op_a;
	logic signed [SAMPLE_W-1:0]  op_b;
	logic signed [PROD_W-1:0]    prod;
	logic signed [ACC_W-1:0]     sum;
	logic signed [PRED_VAL_W-1:0] pred_val;
	logic [NIB_W-1:0]            nib;
	logic signed [SHIFTED_W-1:0] nib_ext;
	logic signed [SHIFTED_W-1:0] shifted;
	logic signed [TOTAL_W-1:0]   total;
	logic signed [SAMPLE_W-1:0]  sat;

	// One multiplier serves both taps: a0 * newer, then a1 * older.
	assign op_a = ctrl.mul_sel ? a1_q : a0_q;
	assign op_b = ctrl.mul_sel ? ho_q : hn_q;
	assign prod = op_a * op_b;

	always_comb begin
		sum      = acc_q + $signed({prod_q[PROD_W-1], prod_q});
		// Dropping the low bits of a two's complement value floors it.
		pred_val = $signed(sum[ACC_W-1:PRED_SHIFT]);
		nib      = payload_q[PAYLOAD_W-1 -: NIB_W];
		nib_ext  = $signed({{(SHIFTED_W-NIB_W){nib[NIB_W-1]}}, nib});
		shifted  = nib_ext <<< scale_q;
		total    = $signed({pred_val[PRED_VAL_W-1], pred_val})
		         + $signed({{(TOTAL_W-SHIFTED_W){shifted[SHIFTED_W-1]}}, shifted});
		// Saturate whenever the bits above the sample do not all match its sign.
		if (total[TOTAL_W-1:SAMPLE_W-1] == '0 || total[TOTAL_W-1:SAMPLE_W-1] == '1) begin
			sat = $signed(total[SAMPLE_W-1:0]);
		end else begin
			sat = total[TOTAL_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a0_q      <= coef_a0;
			a1_q      <= coef_a1;
			scale_q   <= scale;
			payload_q <= payload;
		end else if (ctrl.emit) begin
			payload_q <= payload_q << NIB_W;
		end
		if (ctrl.mul_en) begin
			prod_q <= prod;
			if (ctrl.mul_sel) acc_q <= $signed({prod_q[PROD_W-1], prod_q});
		end
		if (ctrl.emit) sample_q <= sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hn_q <= '0;
			ho_q <= '0;
		end else if (ctrl.start && load_history) begin
			hn_q <= history_newer;
			ho_q <= history_older;
		end else if (ctrl.emit) begin
			ho_q <= hn_q;
			hn_q <= sat;
		end
	end

	assign sample = sample_q;

endmodule

// ===== design/afd_seq.sv =====
// Frame sequencer: steps the shared multiplier and owns the output handshake.
`include "assert_macros.svh"

module afd_seq
	import afd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  frame_valid,
	output logic  frame_stall,
	output logic  pcm_valid,
	input  logic  pcm_stall,
	output logic  last,
	output ctrl_t ctrl
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_last_q;
	logic             frame_accept;
	logic             out_free;

	assign frame_stall  = (state_q != ST_IDLE);
	assign frame_accept = frame_valid && !frame_stall;
	assign out_free     = !out_valid_q || !pcm_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (frame_valid) state_d = ST_MUL0;
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = (cnt_q == LAST_IDX) ? ST_IDLE : ST_MUL0;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: ctrl.start = frame_valid;
			ST_MUL0: ctrl.mul_en = 1'b1;
			ST_MUL1: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = 1'b1;
			end
			ST_EMIT: ctrl.emit = out_free;
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (frame_accept) begin
				cnt_q <= '0;
			end else if (ctrl.emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
				out_last_q  <= (cnt_q == LAST_IDX);
			end else if (!pcm_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pcm_valid = out_valid_q;
	assign last      = out_last_q;

	`AFD_ASSERT(a_no_overwrite, ctrl.emit |-> !(out_valid_q && pcm_stall), "sample register overwritten while stalled")
	`AFD_ASSERT(a_last_ends_frame, (ctrl.emit && cnt_q == LAST_IDX) |=> (state_q == ST_IDLE && out_last_q), "last sample did not end the frame")
	`AFD_ASSERT(a_accept_starts, frame_accept |=> (state_q == ST_MUL0 && cnt_q == '0), "accepted frame did not start a fresh count")
	`AFD_ASSERT_RST(a_reset_clear, !arst_n |=> (!out_valid_q && state_q == ST_IDLE), "reset left sequencer busy")

endmodule

// ===== design/adpcm_frame_decoder_unit.sv =====
// Top level of the 4-bit ADPCM frame decoder.
//
// Each request carries one 8-byte frame (header plus fourteen nibbles) and
// yields fourteen saturated 16-bit samples, the fourteenth marked by last.
// Every sample passes through one shared 16x16 multiplier twice (a0 *
// newer, a1 * older) and then an accumulate, shift and saturate step
// that also updates the history. Output stalls extend the emit cycle of
// the waiting sample. A new frame is taken once the last sample of the
// previous one sits in the output register. The coefficient banks are
// written through the configuration port, which is always ready and
// should be used only while no frame is in flight.
module adpcm_frame_decoder_unit
	import afd_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_INDEX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        frame_valid,
	output logic                        frame_stall,
	input  logic [HEADER_W-1:0]         frame_header,
	input  logic [PAYLOAD_W-1:0]        frame_payload,
	input  logic                        load_history,
	input  logic signed [SAMPLE_W-1:0]  history_newer,
	input  logic signed [SAMPLE_W-1:0]  history_older,
	output logic                        pcm_valid,
	input  logic                        pcm_stall,
	output logic signed [SAMPLE_W-1:0]  sample,
	output logic                        last
);

	ctrl_t                     ctrl;
	logic signed [COEF_W-1:0]  coef_a0, coef_a1;

	assign cfg_ready = 1'b1;

	afd_coef_regs u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.pred     (frame_header[HEADER_W-1:SCALE_W]),
		.a0       (coef_a0),
		.a1       (coef_a1)
	);

	afd_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.pcm_valid   (pcm_valid),
		.pcm_stall   (pcm_stall),
		.last        (last),
		.ctrl        (ctrl)
	);

	afd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.scale         (frame_header[SCALE_W-1:0]),
		.payload       (frame_payload),
		.load_history  (load_history),
		.history_newer (history_newer),
		.history_older (history_older),
		.coef_a0       (coef_a0),
		.coef_a1       (coef_a1),
		.sample        (sample)
	);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the ADPCM frame decoder unit.
module testbench;
	import afd_pkg::*;

	localparam int PRED_COUNT     = 2 * BANK_COUNT;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int RANDOM_FRAMES  = 28;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COEF_BANK_0,
		REG_COEF_BANK_1,
		REG_COEF_BANK_2,
		REG_COEF_BANK_3
	} coef_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} pcm_item_t;

	class pcm_scoreboard;
		logic [CFG_DATA_W-1:0]      coef_bank [BANK_COUNT];
		logic signed [SAMPLE_W-1:0] hist_newer;
		logic signed [SAMPLE_W-1:0] hist_older;
		pcm_item_t                  expected_pcm [$];
		int                         errors;

		function new();
			foreach (coef_bank[b]) coef_bank[b] = '0;
			hist_newer = '0;
			hist_older = '0;
			errors = 0;
		endfunction

		function void write_coef(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index < BANK_COUNT) coef_bank[index] = data;
		endfunction

		// Decodes one accepted frame into its fourteen expected samples.
		function void note_frame(logic [HEADER_W-1:0] header, logic [PAYLOAD_W-1:0] payload,
				logic load, logic signed [SAMPLE_W-1:0] newer,
				logic signed [SAMPLE_W-1:0] older);
			logic [PRED_W-1:0]         pred;
			logic [SCALE_W-1:0]        scale;
			logic [CFG_DATA_W-1:0]     word;
			logic signed [COEF_W-1:0]  a0;
			logic signed [COEF_W-1:0]  a1;
			logic signed [NIB_W-1:0]   nib;
			logic signed [ACC_W-1:0]   pred_sum;
			logic signed [ACC_W:0]     total;
			pcm_item_t                 item;
			pred = header[HEADER_W-1 -: PRED_W];
			scale = header[SCALE_W-1:0];
			if (load) begin
				hist_newer = newer;
				hist_older = older;
			end
			if (pred >= PRED_COUNT) pred = '0;
			word = coef_bank[pred >> 1];
			if (pred[0]) word = word >> (2 * COEF_W);
			a0 = word[COEF_W-1:0];
			a1 = word[2*COEF_W-1:COEF_W];
			for (int i = 0; i < FRAME_SAMPLES; i++) begin
				nib = payload[PAYLOAD_W-1-NIB_W*i -: NIB_W];
				// The sum is formed at 33 bits so that two full-scale products never wrap.
				pred_sum = a0 * hist_newer + a1 * hist_older;
				total = nib;
				total = total <<< scale;
				total = total + (pred_sum >>> PRED_SHIFT);
				if (total > SAMPLE_MAX) begin
					item.sample = SAMPLE_MAX;
				end else if (total < SAMPLE_MIN) begin
					item.sample = SAMPLE_MIN;
				end else begin
					item.sample = total[SAMPLE_W-1:0];
				end
				item.last = (i == FRAME_SAMPLES - 1);
				hist_older = hist_newer;
				hist_newer = item.sample;
				expected_pcm.push_back(item);
			end
		endfunction

		function void check_sample(logic signed [SAMPLE_W-1:0] got_sample, logic got_last);
			pcm_item_t want;
			if (expected_pcm.size() == 0) begin
				errors++;
				$display("%0t: unexpected sample: expected none, actual %0d last %0b",
					$time, got_sample, got_last);
				return;
			end
			want = expected_pcm.pop_front();
			if (want.sample !== got_sample) begin
				errors++;
				$display("%0t: sample mismatch: expected %0d, actual %0d",
					$time, want.sample, got_sample);
			end
			if (want.last !== got_last) begin
				errors++;
				$display("%0t: last mismatch: expected %0b, actual %0b",
					$time, want.last, got_last);
			end
		endfunction

		function int pending();
			return expected_pcm.size();
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       frame_valid = 1'b0;
	logic                       frame_stall;
	logic [HEADER_W-1:0]        frame_header = '0;
	logic [PAYLOAD_W-1:0]       frame_payload = '0;
	logic                       load_history = 1'b0;
	logic signed [SAMPLE_W-1:0] history_newer = '0;
	logic signed [SAMPLE_W-1:0] history_older = '0;
	logic                       pcm_valid;
	logic                       pcm_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;

	pcm_scoreboard sb;
	int            gap_pct = 0;
	int            stall_left = 0;
	int            quiet_cycles = 0;

	adpcm_frame_decoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.frame_valid   (frame_valid),
		.frame_stall   (frame_stall),
		.frame_header  (frame_header),
		.frame_payload (frame_payload),
		.load_history  (load_history),
		.history_newer (history_newer),
		.history_older (history_older),
		.pcm_valid     (pcm_valid),
		.pcm_stall     (pcm_stall),
		.sample        (sample),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output side stalls in bursts, each begun with a chance of gap_pct percent.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			pcm_stall = 1'b1;
			stall_left--;
		end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			pcm_stall = 1'b1;
			stall_left = $urandom_range(3);
		end else begin
			pcm_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (cfg_valid && cfg_ready) begin
				sb.write_coef(cfg_index, cfg_data);
				quiet_cycles = 0;
			end
			if (frame_valid && !frame_stall) begin
				sb.note_frame(frame_header, frame_payload, load_history, history_newer,
					history_older);
				quiet_cycles = 0;
			end
			if (pcm_valid && !pcm_stall) begin
				sb.check_sample(sample, last);
				quiet_cycles = 0;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic load_coef_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Valid stays high after a request unless a gap is drawn, so that
	// back-to-back frames go in without a bubble.
	task automatic send_frame(input logic [HEADER_W-1:0] header,
			input logic [PAYLOAD_W-1:0] payload, input logic load,
			input logic signed [SAMPLE_W-1:0] newer, input logic signed [SAMPLE_W-1:0] older);
		frame_valid = 1'b1;
		frame_header = header;
		frame_payload = payload;
		load_history = load;
		history_newer = newer;
		history_older = older;
		@(posedge clk);
		while (frame_stall) @(posedge clk);
		@(negedge clk);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			frame_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		frame_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [PAYLOAD_W-1:0]       payload;
		logic [HEADER_W-1:0]        header;
		logic [CFG_DATA_W-1:0]      bank;
		logic signed [SAMPLE_W-1:0] hn;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		gap_pct = 25;

		// All coefficients are still zero, so only the nibbles reach the output.
		send_frame('0, 56'h0123_4567_89AB_CD, 1'b1, 16'sd12345, -16'sd1);
		wait_drained();

		load_coef_reg(REG_COEF_BANK_0, 64'h8000_7FFF_FC00_0800);
		load_coef_reg(REG_COEF_BANK_1, 64'h7FFF_7FFF_0000_1000);
		load_coef_reg(REG_COEF_BANK_2, 64'h8000_8000_F800_0E00);
		load_coef_reg(REG_COEF_BANK_3, 64'hFFFF_0001_C000_3FFF);
		for (int idx = BANK_COUNT; idx < 2**CFG_INDEX_W; idx++) begin
			load_coef_reg(CFG_INDEX_W'(idx), {$urandom, $urandom});
		end

		// Every predictor index, the upper eight falling back to predictor zero,
		// with every scale shift once.
		for (int p = 0; p < 2**PRED_W; p++) begin
			case (p % 5)
				0: payload = '0;
				1: payload = '1;
				2: payload = {PAYLOAD_W/NIB_W{4'h7}};
				3: payload = {PAYLOAD_W/NIB_W{4'h8}};
				default: payload = PAYLOAD_W'({$urandom, $urandom});
			endcase
			hn = p[0] ? SAMPLE_MAX : SAMPLE_MIN;
			send_frame({PRED_W'(p), SCALE_W'(p * 7)}, payload, p % 3 == 0, hn, ~hn);
		end
		send_frame({4'd3, 4'd15}, {PAYLOAD_W/NIB_W{4'h7}}, 1'b1, SAMPLE_MAX, SAMPLE_MAX);
		// Two full-scale products of negative operands sum past the signed 32-bit range.
		send_frame({4'd5, 4'd0}, '0, 1'b1, SAMPLE_MIN, SAMPLE_MIN);
		send_frame({4'd5, 4'd12}, {PAYLOAD_W/NIB_W{4'h8}}, 1'b1, SAMPLE_MAX, SAMPLE_MIN);

		for (int setting = 0; setting < 4; setting++) begin
			wait_drained();
			for (int idx = 0; idx < 2**CFG_INDEX_W; idx++) begin
				case (setting)
					0: bank = '0;
					1: bank = '1;
					2: bank = {$urandom, $urandom};
					default: begin
						for (int k = 0; k < 2; k++) begin
							bank[32*k +: 32] = {16'(-int'($urandom_range(2047))),
								16'($urandom_range(4095))};
						end
					end
				endcase
				load_coef_reg(CFG_INDEX_W'(idx), bank);
			end
			gap_pct = (setting == 3) ? 0 : 15 + 15 * setting;
			for (int n = 0; n < RANDOM_FRAMES; n++) begin
				if (setting == 1 && n == RANDOM_FRAMES / 2) wait_drained();
				header = {PRED_W'($urandom), ($urandom_range(3) == 0) ?
					SCALE_W'($urandom) : SCALE_W'($urandom_range(11))};
				send_frame(header, PAYLOAD_W'({$urandom, $urandom}), $urandom_range(3) == 0,
					SAMPLE_W'($urandom), SAMPLE_W'($urandom));
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/afd_pkg.sv
design/afd_coef_regs.sv
design/afd_datapath.sv
design/afd_seq.sv
design/adpcm_frame_decoder_unit.sv
tb/sv/testbench.sv
